// ----- hdl/encoder_speed_step_regulator_unit_assert.svh -----
`ifndef ENCODER_SPEED_STEP_REGULATOR_UNIT_ASSERT_SVH
`define ENCODER_SPEED_STEP_REGULATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ESR_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("implication check failed");

// next-cycle implication
`define ESR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

// ----- hdl/esr_pkg.sv -----
package esr_pkg;

	// behavior constants
	localparam int unsigned UPDATE_PERIOD_MS = 100;
	localparam int unsigned WINDOW_MS        = 1;
	localparam int unsigned COUNT_MAX        = 255;

	// register widths and reset values
	localparam int STEP_W  = 10;
	localparam int BAND_W  = 12;
	localparam int DUTY_W  = 14;
	localparam int SPEED_W = 15;
	localparam int ENC_W   = 16;
	localparam int TIME_W  = 32;
	localparam int ACC_W   = 16;
	localparam int MAG_W   = ENC_W + 1;
	localparam int CNT_W   = 8;
	localparam int CFG_W   = DUTY_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [STEP_W-1:0] LARGE_STEP_RST = 10'd50;
	localparam logic [STEP_W-1:0] SMALL_STEP_RST = 10'd1;
	localparam logic [BAND_W-1:0] NEAR_BAND_RST  = 12'd30;
	localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 14'd9900;

	// time % period by reciprocal: estimate is low by at most one period
	localparam longint unsigned RecipFull = (64'd1 << 32) / UPDATE_PERIOD_MS;
	localparam logic [TIME_W-1:0] PERIOD_RECIP = RecipFull[31:0];
	localparam int REM_W = 17;
	localparam logic [REM_W-1:0] PERIOD_R = REM_W'(UPDATE_PERIOD_MS);
	localparam logic [REM_W-1:0] WINDOW_R = REM_W'(WINDOW_MS);

	// floor(n*200/3) = (n * 200 * 43691) >> 17, exact for n*200 below 2^17
	localparam logic [31:0] SPEED_MUL   = 32'd8738200;
	localparam int          SPEED_SHIFT = 17;
	localparam logic [CNT_W-1:0] COUNT_MAX_C = CNT_W'(COUNT_MAX);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LARGE_STEP = 2'd0,
		CFG_SMALL_STEP = 2'd1,
		CFG_NEAR_BAND  = 2'd2,
		CFG_DUTY_LIMIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0] large_step;
		logic [STEP_W-1:0] small_step;
		logic [BAND_W-1:0] near_band;
		logic [DUTY_W-1:0] duty_limit;
	} cfg_t;

	// pipeline control handed to the stage modules
	typedef struct packed {
		logic adv;
		logic vld_s1;
	} stg_ctl_t;

endpackage

// ----- hdl/esr_cfg.sv -----
module esr_cfg import esr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.large_step <= LARGE_STEP_RST;
			cfg_q.small_step <= SMALL_STEP_RST;
			cfg_q.near_band  <= NEAR_BAND_RST;
			cfg_q.duty_limit <= DUTY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LARGE_STEP: cfg_q.large_step <= cfg_data[STEP_W-1:0];
				CFG_SMALL_STEP: cfg_q.small_step <= cfg_data[STEP_W-1:0];
				CFG_NEAR_BAND:  cfg_q.near_band  <= cfg_data[BAND_W-1:0];
				CFG_DUTY_LIMIT: cfg_q.duty_limit <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/esr_win.sv -----
module esr_win import esr_pkg::*; (
	input  logic              clk,
	input  stg_ctl_t          ctl,
	input  logic [TIME_W-1:0] now_s1,
	output logic              upd_s4
);

	logic [TIME_W-1:0]   quo_s2;
	logic [REM_W-1:0]    now_s2;
	logic [REM_W-1:0]    now_s3;
	logic [REM_W-1:0]    qp_s3;
	logic [2*TIME_W-1:0] prod;
	logic [2*REM_W-1:0]  qp_full;
	logic [REM_W-1:0]    rem_est;
	logic [REM_W-1:0]    rem;

	assign prod = 64'(now_s1) * 64'(PERIOD_RECIP);

	// only the low bits matter: the true estimate of the remainder is below 2^17
	assign qp_full = quo_s2[REM_W-1:0] * PERIOD_R;

	assign rem_est = now_s3 - qp_s3;
	assign rem     = (rem_est >= PERIOD_R) ? rem_est - PERIOD_R : rem_est;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			quo_s2 <= prod[2*TIME_W-1:TIME_W];
			now_s2 <= now_s1[REM_W-1:0];
			qp_s3  <= qp_full[REM_W-1:0];
			now_s3 <= now_s2;
			upd_s4 <= rem < WINDOW_R;
		end
	end

endmodule

// ----- hdl/esr_tgt.sv -----
module esr_tgt import esr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  stg_ctl_t           ctl,
	input  logic               circle_s1,
	input  logic               cross_s1,
	output logic [SPEED_W-1:0] speed_s3
);

	logic [CNT_W-1:0] steps_q;
	logic             up_armed_q;
	logic             down_armed_q;
	logic [CNT_W-1:0] steps_s2;
	logic             up_arm;
	logic             down_arm;
	logic             inc;
	logic             dec;
	logic [CNT_W-1:0] steps_inc;
	logic [CNT_W-1:0] steps_nxt;
	logic [31:0]      speed_prod;

	// a button arms on any word where it is released
	assign up_arm   = up_armed_q | ~circle_s1;
	assign down_arm = down_armed_q | ~cross_s1;
	assign inc      = circle_s1 & up_arm;
	assign dec      = cross_s1 & down_arm;

	// increase first, then decrease, both saturating
	assign steps_inc = (inc && steps_q < COUNT_MAX_C) ? steps_q + 1'b1 : steps_q;
	assign steps_nxt = (dec && steps_inc != '0) ? steps_inc - 1'b1 : steps_inc;

	assign speed_prod = 32'(steps_s2) * SPEED_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q      <= '0;
			up_armed_q   <= 1'b0;
			down_armed_q <= 1'b0;
		end else if (ctl.adv && ctl.vld_s1) begin
			steps_q      <= steps_nxt;
			up_armed_q   <= up_arm & ~inc;
			down_armed_q <= down_arm & ~dec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			steps_s2 <= steps_nxt;
			speed_s3 <= speed_prod[SPEED_SHIFT+SPEED_W-1:SPEED_SHIFT];
		end
	end

endmodule

// ----- hdl/encoder_speed_step_regulator_unit.sv -----
// channel   handshake                    payload
// item      item_valid / item_ready      circle_pressed cross_pressed enc_delta time_ms
// result    result_valid / result_ready  update_done motor_duty target_speed elapsed_ms
// config    cfg_we (no wait)             cfg_index cfg_data
//
// one word accepted per cycle while the pipe is not held; each result passes s1 to s4 and the result register
// the pipe depth is set by the time-window remainder: multiply, multiply, compare
// the whole pipe holds when a result waits and result_ready is low
// arst_n clears valid bits, target count, buttons, duty and registers to defaults
module encoder_speed_step_regulator_unit import esr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 circle_pressed,
	input  logic                 cross_pressed,
	input  logic signed [ENC_W-1:0] enc_delta,
	input  logic [TIME_W-1:0]    time_ms,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic                 update_done,
	output logic [DUTY_W-1:0]    motor_duty,
	output logic [SPEED_W-1:0]   target_speed,
	output logic [TIME_W-1:0]    elapsed_ms,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t     cfg;
	stg_ctl_t ctl;
	logic     adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic circle_s1, cross_s1;
	logic signed [ENC_W-1:0] enc_s1;
	logic [TIME_W-1:0] now_s1, now_s2, now_s3, now_s4;
	logic [MAG_W-1:0]  mag_s2, mag_s3, mag_s4;
	logic [SPEED_W-1:0] speed_s3, speed_s4;
	logic upd_s4;

	logic signed [ACC_W-1:0] acc_q;
	logic [TIME_W-1:0]       last_q;
	logic                    result_valid_q;
	logic                    update_done_q;
	logic [DUTY_W-1:0]       duty_q;
	logic [SPEED_W-1:0]      speed_out_q;
	logic [TIME_W-1:0]       elapsed_q;

	logic signed [MAG_W-1:0] enc_ext;
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        spd;
	logic                    gt, lt;
	logic [MAG_W-1:0]        err;
	logic [STEP_W-1:0]       step;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] acc_nxt;
	logic [DUTY_W-1:0]       duty_nxt;

	assign adv        = !result_valid_q || result_ready;
	assign item_ready = adv;
	assign ctl.adv    = adv;
	assign ctl.vld_s1 = vld_s1;

	esr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	esr_win u_win (
		.clk    (clk),
		.ctl    (ctl),
		.now_s1 (now_s1),
		.upd_s4 (upd_s4)
	);

	esr_tgt u_tgt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.circle_s1 (circle_s1),
		.cross_s1  (cross_s1),
		.speed_s3  (speed_s3)
	);

	// magnitude of the encoder count, the most negative value included
	assign enc_ext = MAG_W'(enc_s1);
	assign mag     = enc_ext[MAG_W-1] ? MAG_W'(-enc_ext) : MAG_W'(enc_ext);

	// duty step on the update word
	assign spd  = MAG_W'(speed_s4);
	assign gt   = mag_s4 > spd;
	assign lt   = mag_s4 < spd;
	assign err  = gt ? mag_s4 - spd : spd - mag_s4;
	assign step = (err > MAG_W'(cfg.near_band)) ? cfg.large_step : cfg.small_step;
	assign sum  = gt ? (ACC_W+1)'(acc_q) - (ACC_W+1)'(signed'({1'b0, step}))
	                 : (ACC_W+1)'(acc_q) + (ACC_W+1)'(signed'({1'b0, step}));

	always_comb begin
		acc_nxt = acc_q;
		if (gt || lt) begin
			if (sum > (ACC_W+1)'(signed'(17'sd32767))) begin
				acc_nxt = 16'sd32767;
			end else if (sum < -(ACC_W+1)'(signed'(17'sd32768))) begin
				acc_nxt = -16'sd32768;
			end else begin
				acc_nxt = sum[ACC_W-1:0];
			end
		end
		if (acc_nxt[ACC_W-1]) begin
			duty_nxt = '0;
		end else if (acc_nxt[ACC_W-2:0] > 15'(cfg.duty_limit)) begin
			duty_nxt = cfg.duty_limit;
		end else begin
			duty_nxt = acc_nxt[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			vld_s4         <= 1'b0;
			result_valid_q <= 1'b0;
			acc_q          <= '0;
			last_q         <= '0;
			duty_q         <= '0;
		end else if (adv) begin
			vld_s1         <= item_valid;
			vld_s2         <= vld_s1;
			vld_s3         <= vld_s2;
			vld_s4         <= vld_s3;
			result_valid_q <= vld_s4;
			if (vld_s4 && upd_s4) begin
				acc_q  <= acc_nxt;
				last_q <= now_s4;
				duty_q <= duty_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			circle_s1     <= circle_pressed;
			cross_s1      <= cross_pressed;
			enc_s1        <= enc_delta;
			now_s1        <= time_ms;
			mag_s2        <= mag;
			now_s2        <= now_s1;
			mag_s3        <= mag_s2;
			now_s3        <= now_s2;
			mag_s4        <= mag_s3;
			now_s4        <= now_s3;
			speed_s4      <= speed_s3;
			update_done_q <= upd_s4;
			speed_out_q   <= speed_s4;
			elapsed_q     <= upd_s4 ? now_s4 - last_q : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign update_done  = update_done_q;
	assign motor_duty   = duty_q;
	assign target_speed = speed_out_q;
	assign elapsed_ms   = elapsed_q;

endmodule

// ----- hdl/esr_chk.sv -----
`include "encoder_speed_step_regulator_unit_assert.svh"

module esr_chk import esr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input logic               update_done,
	input logic [DUTY_W-1:0]  motor_duty,
	input logic [SPEED_W-1:0] target_speed,
	input logic [TIME_W-1:0]  elapsed_ms
);

	// a stalled result word stays put
	`ESR_ASSERT_NEXT(a_hold_word, clk, arst_n, result_valid && !result_ready, result_valid && $stable(motor_duty) && $stable(elapsed_ms))

	// elapsed time only reported on update words
	`ESR_ASSERT_IMPLY(a_elapsed_zero, clk, arst_n, result_valid && !update_done, elapsed_ms == '0)

	// duty moves only on update words
	`ESR_ASSERT_IMPLY(a_duty_held, clk, arst_n, result_valid && !update_done, motor_duty == $past(motor_duty))

	// target never exceeds the speed for the top count
	`ESR_ASSERT_IMPLY(a_speed_range, clk, arst_n, result_valid, target_speed <= SPEED_W'(17000))

endmodule

bind encoder_speed_step_regulator_unit esr_chk u_esr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.update_done  (update_done),
	.motor_duty   (motor_duty),
	.target_speed (target_speed),
	.elapsed_ms   (elapsed_ms)
);
